// File: sv/multi_queue_fifo_manager_macros.svh
// assertion helpers, expect clk_i and rst_ni in scope
`ifndef MULTI_QUEUE_FIFO_MANAGER_MACROS_SVH
`define MULTI_QUEUE_FIFO_MANAGER_MACROS_SVH

// same-cycle implication
`define MQFM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mqfm assertion failed");

// next-cycle implication
`define MQFM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mqfm assertion failed");

`endif

// File: sv/mqfm_pkg.sv
package mqfm_pkg;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } mqfm_action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } mqfm_status_e;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } mqfm_state_e;

  typedef struct packed {
    mqfm_status_e       status;
    logic [1:0]         out_queue;
    logic signed [31:0] out_id;
    logic signed [31:0] out_grade;
    logic               now_empty;
  } mqfm_result_t;

endpackage

// File: sv/mqfm_if.sv
interface mqfm_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [1:0]         queue_sel;
  logic signed [31:0] rec_id;
  logic signed [31:0] rec_grade;

  modport source (output valid, action, queue_sel, rec_id, rec_grade, input ready);
  modport sink (input valid, action, queue_sel, rec_id, rec_grade, output ready);
endinterface

interface mqfm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [1:0]         out_queue;
  logic signed [31:0] out_id;
  logic signed [31:0] out_grade;
  logic               now_empty;

  modport source (output valid, status, out_queue, out_id, out_grade, now_empty, input ready);
  modport sink (input valid, status, out_queue, out_id, out_grade, now_empty, output ready);
endinterface

// File: sv/mqfm_ram.sv
module mqfm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/mqfm_ctrl.sv
`include "multi_queue_fifo_manager_macros.svh"

module mqfm_ctrl #(
  parameter int NUM_QUEUES = 3,
  parameter int POOL_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mqfm_in_if.sink                       in_i,
  input  logic                          out_free_i,
  output logic                          res_fire_o,
  output mqfm_pkg::mqfm_result_t        res_o,
  output logic                          link_re_o,
  output logic [$clog2(POOL_DEPTH)-1:0] link_raddr_o,
  input  logic [$clog2(POOL_DEPTH)-1:0] link_rdata_i,
  output logic                          link_we_o,
  output logic [$clog2(POOL_DEPTH)-1:0] link_waddr_o,
  output logic [$clog2(POOL_DEPTH)-1:0] link_wdata_o,
  output logic                          entry_re_o,
  output logic [$clog2(POOL_DEPTH)-1:0] entry_raddr_o,
  input  logic [63:0]                   entry_rdata_i,
  output logic                          entry_we_o,
  output logic [$clog2(POOL_DEPTH)-1:0] entry_waddr_o,
  output logic [63:0]                   entry_wdata_o
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [CW-1:0] DepthC = CW'(POOL_DEPTH);

  typedef struct packed {
    logic               action;
    logic [1:0]         qsel;
    logic [QW-1:0]      qidx;
    logic               in_range;
    logic signed [31:0] id;
    logic signed [31:0] grade;
  } op_t;

  mqfm_pkg::mqfm_state_e state_q, state_d;
  op_t                   op_q;

  logic [AW-1:0]         heads_q [NUM_QUEUES];
  logic [AW-1:0]         heads_d [NUM_QUEUES];
  logic [AW-1:0]         tails_q [NUM_QUEUES];
  logic [AW-1:0]         tails_d [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] nonempty_q, nonempty_d;
  // recycled free chain plus fill mark for never-used entries
  logic [AW-1:0]         rec_head_q, rec_head_d;
  logic [CW-1:0]         rec_cnt_q, rec_cnt_d;
  logic [CW-1:0]         fill_q, fill_d;

  logic          accept;
  logic          in_range;
  logic [QW-1:0] in_qidx;
  logic [QW-1:0] sidx;
  logic          pool_full;
  logic [AW-1:0] new_e;
  logic [AW-1:0] head_e;

  assign in_i.ready = (state_q == mqfm_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign in_range   = 32'(in_i.queue_sel) < NUM_QUEUES;
  assign in_qidx    = QW'(in_i.queue_sel);
  assign sidx       = in_range ? in_qidx : '0;

  // reads launched at the accept edge, data valid in the update cycle
  assign link_re_o     = accept;
  assign link_raddr_o  = (in_i.action == mqfm_pkg::ACT_DEQ) ? heads_q[sidx] : rec_head_q;
  assign entry_re_o    = accept && (in_i.action == mqfm_pkg::ACT_DEQ);
  assign entry_raddr_o = heads_q[sidx];

  assign pool_full = (rec_cnt_q == '0) && (fill_q == DepthC);
  assign new_e     = (rec_cnt_q != '0) ? rec_head_q : fill_q[AW-1:0];
  assign head_e    = heads_q[op_q.qidx];

  always_comb begin
    state_d    = state_q;
    heads_d    = heads_q;
    tails_d    = tails_q;
    nonempty_d = nonempty_q;
    rec_head_d = rec_head_q;
    rec_cnt_d  = rec_cnt_q;
    fill_d     = fill_q;

    res_fire_o      = 1'b0;
    res_o.status    = mqfm_pkg::STAT_OK;
    res_o.out_queue = op_q.qsel;
    res_o.out_id    = '0;
    res_o.out_grade = '0;
    res_o.now_empty = 1'b1;

    link_we_o     = 1'b0;
    link_waddr_o  = '0;
    link_wdata_o  = '0;
    entry_we_o    = 1'b0;
    entry_waddr_o = new_e;
    entry_wdata_o = {op_q.id, op_q.grade};

    unique case (state_q)
      mqfm_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = mqfm_pkg::ST_UPDATE;
        end
      end
      mqfm_pkg::ST_UPDATE: begin
        res_fire_o = out_free_i;
        if (out_free_i) begin
          state_d = mqfm_pkg::ST_IDLE;
        end
        if (!op_q.in_range) begin
          res_o.status = (op_q.action == mqfm_pkg::ACT_DEQ) ? mqfm_pkg::STAT_EMPTY
                                                            : mqfm_pkg::STAT_FULL;
        end else if (op_q.action == mqfm_pkg::ACT_ENQ) begin
          if (pool_full) begin
            res_o.status    = mqfm_pkg::STAT_FULL;
            res_o.now_empty = !nonempty_q[op_q.qidx];
          end else begin
            res_o.now_empty = 1'b0;
            entry_we_o      = out_free_i;
            // append behind the current tail
            link_we_o       = out_free_i && nonempty_q[op_q.qidx];
            link_waddr_o    = tails_q[op_q.qidx];
            link_wdata_o    = new_e;
            if (out_free_i) begin
              if (rec_cnt_q != '0) begin
                rec_head_d = link_rdata_i;
                rec_cnt_d  = rec_cnt_q - 1'b1;
              end else begin
                fill_d = fill_q + 1'b1;
              end
              if (!nonempty_q[op_q.qidx]) begin
                heads_d[op_q.qidx] = new_e;
              end
              tails_d[op_q.qidx]    = new_e;
              nonempty_d[op_q.qidx] = 1'b1;
            end
          end
        end else begin
          if (!nonempty_q[op_q.qidx]) begin
            res_o.status = mqfm_pkg::STAT_EMPTY;
          end else begin
            res_o.out_id    = entry_rdata_i[63:32];
            res_o.out_grade = entry_rdata_i[31:0];
            res_o.now_empty = (head_e == tails_q[op_q.qidx]);
            // freed entry goes on front of the recycled chain
            link_we_o       = out_free_i;
            link_waddr_o    = head_e;
            link_wdata_o    = rec_head_q;
            if (out_free_i) begin
              if (head_e == tails_q[op_q.qidx]) begin
                nonempty_d[op_q.qidx] = 1'b0;
              end else begin
                heads_d[op_q.qidx] = link_rdata_i;
              end
              rec_head_d = head_e;
              rec_cnt_d  = rec_cnt_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = mqfm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mqfm_pkg::ST_IDLE;
      nonempty_q <= '0;
      rec_head_q <= '0;
      rec_cnt_q  <= '0;
      fill_q     <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        heads_q[i] <= '0;
        tails_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      nonempty_q <= nonempty_d;
      rec_head_q <= rec_head_d;
      rec_cnt_q  <= rec_cnt_d;
      fill_q     <= fill_d;
      heads_q    <= heads_d;
      tails_q    <= tails_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q.action   <= in_i.action;
      op_q.qsel     <= in_i.queue_sel;
      op_q.qidx     <= sidx;
      op_q.in_range <= in_range;
      op_q.id       <= in_i.rec_id;
      op_q.grade    <= in_i.rec_grade;
    end
  end

  `MQFM_ASSERT_IMP(a_no_idle_write, state_q == mqfm_pkg::ST_IDLE, !link_we_o && !entry_we_o)
  `MQFM_ASSERT_IMP(a_pool_count, 1'b1, rec_cnt_q <= fill_q && fill_q <= DepthC)
  `MQFM_ASSERT_NXT(a_empty_flag, res_fire_o && op_q.in_range, nonempty_q[$past(op_q.qidx)] != $past(res_o.now_empty))

endmodule

// File: sv/multi_queue_fifo_manager.sv
// channel  dir  beat payload                                   handshake
// in_i     in   action, queue_sel, rec_id, rec_grade           valid/ready
// out_o    out  status, out_queue, out_id, out_grade, now_empty valid/ready
//
// the accept edge launches the link ram read, and the entry ram read for a
// dequeue; the update state writes back link, entry and queue table, loads
// the result; an item is accepted again in the cycle after write-back
// reset is immediate: untouched entries come from a fill mark, so no ram sweep
// a full output register holds the write-back cycle until out_o.ready
`include "multi_queue_fifo_manager_macros.svh"

module multi_queue_fifo_manager #(
  parameter int NUM_QUEUES = 3,
  parameter int POOL_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mqfm_in_if.sink    in_i,
  mqfm_out_if.source out_o
);

  localparam int AW = $clog2(POOL_DEPTH);

  logic                   res_fire;
  mqfm_pkg::mqfm_result_t res;
  logic                   out_free;

  logic          link_re, link_we;
  logic [AW-1:0] link_raddr, link_waddr, link_wdata, link_rdata;
  logic          entry_re, entry_we;
  logic [AW-1:0] entry_raddr, entry_waddr;
  logic [63:0]   entry_wdata, entry_rdata;

  // output register, one result beat
  logic                   out_valid_q;
  mqfm_pkg::mqfm_result_t out_res_q;

  assign out_free = !out_valid_q || out_o.ready;

  // queue table, allocator and sequencer
  mqfm_ctrl #(
    .NUM_QUEUES (NUM_QUEUES),
    .POOL_DEPTH (POOL_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .out_free_i    (out_free),
    .res_fire_o    (res_fire),
    .res_o         (res),
    .link_re_o     (link_re),
    .link_raddr_o  (link_raddr),
    .link_rdata_i  (link_rdata),
    .link_we_o     (link_we),
    .link_waddr_o  (link_waddr),
    .link_wdata_o  (link_wdata),
    .entry_re_o    (entry_re),
    .entry_raddr_o (entry_raddr),
    .entry_rdata_i (entry_rdata),
    .entry_we_o    (entry_we),
    .entry_waddr_o (entry_waddr),
    .entry_wdata_o (entry_wdata)
  );

  // next pointer per entry, shared by queues and the free chain
  mqfm_ram #(
    .WIDTH (AW),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata)
  );

  // record per entry, id in the upper half
  mqfm_ram #(
    .WIDTH (64),
    .DEPTH (POOL_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .re_i    (entry_re),
    .raddr_i (entry_raddr),
    .rdata_o (entry_rdata),
    .we_i    (entry_we),
    .waddr_i (entry_waddr),
    .wdata_i (entry_wdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_res_q.status;
  assign out_o.out_queue = out_res_q.out_queue;
  assign out_o.out_id    = out_res_q.out_id;
  assign out_o.out_grade = out_res_q.out_grade;
  assign out_o.now_empty = out_res_q.now_empty;

  // a result never lands on a beat that is still waiting
  `MQFM_ASSERT_IMP(a_slot_free, res_fire, !out_valid_q || out_o.ready)

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_Q = 3;
  localparam int POOL_DEPTH = 64;
  localparam logic [1:0] BAD_SEL = 2'(NUM_Q);  // first select with no queue behind it
  localparam int unsigned RANDOM_OPS = 1100;
  localparam int unsigned LONG_HOLD_AT = 200;  // result count where the sink holds off
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    mqfm_pkg::mqfm_action_e action;
    logic [1:0]             sel;
    logic signed [31:0]     id;
    logic signed [31:0]     grade;
    int unsigned            gap;    // idle cycles before the beat is offered
    bit                     drain;  // hold the beat until every reply is back
  } queue_op_t;

  typedef struct packed {
    logic signed [31:0] id;
    logic signed [31:0] grade;
  } record_t;

  logic clk_i;
  logic rst_ni;

  mqfm_in_if  in_if ();
  mqfm_out_if out_if ();

  multi_queue_fifo_manager #(
    .NUM_QUEUES (NUM_Q),
    .POOL_DEPTH (POOL_DEPTH)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // mirror of the shared pool: per-queue record lists plus a free entry count
  record_t                queue_contents[NUM_Q][$];
  int unsigned            free_entries;

  queue_op_t              ops_to_send[$];
  mqfm_pkg::mqfm_result_t replies_due[$];
  int unsigned            gap_max;
  int unsigned            mismatches;

  // driver state
  queue_op_t    cur_op;
  bit           cur_loaded;
  int unsigned  gap_left;

  // monitor state
  int unsigned  replies_seen;
  int unsigned  stall_left;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // known values on every block input before the first edge
  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.action    = 1'b0;
    in_if.queue_sel = '0;
    in_if.rec_id    = '0;
    in_if.rec_grade = '0;
    out_if.ready    = 1'b0;
  end

  // applies one operation to the mirror and returns the reply it should cause
  function automatic mqfm_pkg::mqfm_result_t apply_queue_op(queue_op_t op);
    mqfm_pkg::mqfm_result_t reply;
    record_t                rec;
    reply.status    = mqfm_pkg::STAT_OK;
    reply.out_queue = op.sel;
    reply.out_id    = '0;
    reply.out_grade = '0;
    reply.now_empty = 1'b1;
    if (op.sel >= BAD_SEL) begin
      // no storage behind this select: always empty, never room
      reply.status = (op.action == mqfm_pkg::ACT_DEQ) ? mqfm_pkg::STAT_EMPTY
                                                      : mqfm_pkg::STAT_FULL;
    end else if (op.action == mqfm_pkg::ACT_ENQ) begin
      if (free_entries == 0) begin
        // pool exhausted, queue untouched
        reply.status    = mqfm_pkg::STAT_FULL;
        reply.now_empty = (queue_contents[op.sel].size() == 0);
      end else begin
        rec.id    = op.id;
        rec.grade = op.grade;
        queue_contents[op.sel].push_back(rec);
        free_entries--;
        reply.now_empty = 1'b0;
      end
    end else begin
      if (queue_contents[op.sel].size() == 0) begin
        reply.status = mqfm_pkg::STAT_EMPTY;
      end else begin
        rec = queue_contents[op.sel].pop_front();
        free_entries++;
        reply.out_id    = rec.id;
        reply.out_grade = rec.grade;
        reply.now_empty = (queue_contents[op.sel].size() == 0);
      end
    end
    return reply;
  endfunction

  task automatic add_op(mqfm_pkg::mqfm_action_e act, logic [1:0] sel, logic [31:0] id,
                        logic [31:0] grade, bit drain);
    queue_op_t op;
    op.action = act;
    op.sel    = sel;
    op.id     = id;
    op.grade  = grade;
    op.gap    = $urandom_range(0, gap_max);
    op.drain  = drain;
    ops_to_send.push_back(op);
  endtask

  // input driver: one beat in flight, fed from ops_to_send
  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    logic offer;
    if (!rst_ni) begin
      cur_loaded      = 1'b0;
      gap_left        = 0;
      cur_op.action   = mqfm_pkg::ACT_ENQ;
      cur_op.sel      = '0;
      cur_op.id       = '0;
      cur_op.grade    = '0;
      cur_op.gap      = 0;
      cur_op.drain    = 1'b0;
      in_if.valid     <= 1'b0;
      in_if.action    <= 1'b0;
      in_if.queue_sel <= '0;
      in_if.rec_id    <= '0;
      in_if.rec_grade <= '0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      // beat taken at this edge: its reply is now due
      if (in_if.valid) begin
        replies_due.push_back(apply_queue_op(cur_op));
        cur_loaded = 1'b0;
      end
      if (!cur_loaded && ops_to_send.size() != 0) begin
        cur_op     = ops_to_send.pop_front();
        cur_loaded = 1'b1;
        gap_left   = cur_op.gap;
      end
      offer = 1'b0;
      if (cur_loaded) begin
        if (cur_op.drain && replies_due.size() != 0) begin
          // sender pause: wait for the block to go quiet
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          offer = 1'b1;
        end
      end
      in_if.valid     <= offer;
      in_if.action    <= cur_op.action;
      in_if.queue_sel <= cur_op.sel;
      in_if.rec_id    <= cur_op.id;
      in_if.rec_grade <= cur_op.grade;
    end
  end

  // output monitor: checks each reply beat against the oldest one due
  always @(posedge clk_i or negedge rst_ni) begin : watch_out
    mqfm_pkg::mqfm_result_t due;
    logic                   take;
    if (!rst_ni) begin
      replies_seen = 0;
      stall_left   = 0;
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (replies_due.size() == 0) begin
          $error("reply beat with none due: status %0d queue %0d",
                 out_if.status, out_if.out_queue);
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          if (out_if.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_if.status);
            mismatches++;
          end
          if (out_if.out_queue !== due.out_queue) begin
            $error("out_queue: expected %0d, got %0d", due.out_queue, out_if.out_queue);
            mismatches++;
          end
          if (out_if.out_id !== due.out_id) begin
            $error("out_id: expected %0d, got %0d", due.out_id, out_if.out_id);
            mismatches++;
          end
          if (out_if.out_grade !== due.out_grade) begin
            $error("out_grade: expected %0d, got %0d", due.out_grade, out_if.out_grade);
            mismatches++;
          end
          if (out_if.now_empty !== due.now_empty) begin
            $error("now_empty: expected %0d, got %0d", due.now_empty, out_if.now_empty);
            mismatches++;
          end
        end
        replies_seen++;
        // every fourth stretch of replies runs without sink stalls
        if (replies_seen == LONG_HOLD_AT) stall_left = LONG_HOLD_CYCLES;
        else if ((replies_seen / 128) % 4 == 3) stall_left = 0;
        else stall_left = $urandom_range(0, 10);
      end
      take = 1'b1;
      if (stall_left != 0) begin
        stall_left--;
        take = 1'b0;
      end
      out_if.ready <= take;
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned total;
    int unsigned seg;
    int unsigned seg_len;
    int unsigned enq_pct;
    mqfm_pkg::mqfm_action_e act;
    logic [1:0] sel;

    mismatches   = 0;
    free_entries = POOL_DEPTH;

    // directed: field extremes, every operation, empty dequeue, bad select
    gap_max = 3;
    add_op(mqfm_pkg::ACT_DEQ, 2'd0, 32'h0, 32'h0, 1'b0);          // dequeue from empty queue
    add_op(mqfm_pkg::ACT_ENQ, 2'd0, 32'h7fffffff, 32'h80000000, 1'b0);
    add_op(mqfm_pkg::ACT_ENQ, 2'd0, 32'h80000000, 32'h7fffffff, 1'b0);
    add_op(mqfm_pkg::ACT_ENQ, 2'd1, 32'h00000000, 32'hffffffff, 1'b0);
    add_op(mqfm_pkg::ACT_ENQ, 2'd2, 32'hffffffff, 32'h00000000, 1'b0);
    add_op(mqfm_pkg::ACT_DEQ, 2'd0, 32'hffffffff, 32'hffffffff, 1'b0);
    add_op(mqfm_pkg::ACT_DEQ, 2'd0, 32'h0, 32'h0, 1'b0);          // last entry leaves
    add_op(mqfm_pkg::ACT_DEQ, 2'd0, 32'h0, 32'h0, 1'b0);
    // enqueue and dequeue on a missing queue
    add_op(mqfm_pkg::ACT_ENQ, BAD_SEL, 32'h12345678, 32'h9abcdef0, 1'b0);
    add_op(mqfm_pkg::ACT_DEQ, BAD_SEL, 32'h0, 32'h0, 1'b0);
    add_op(mqfm_pkg::ACT_DEQ, 2'd1, 32'h0, 32'h0, 1'b0);
    add_op(mqfm_pkg::ACT_DEQ, 2'd2, 32'h0, 32'h0, 1'b0);
    // sender waits for drain
    add_op(mqfm_pkg::ACT_ENQ, 2'd2, 32'h55555555, 32'haaaaaaaa, 1'b1);
    add_op(mqfm_pkg::ACT_ENQ, 2'd2, 32'haaaaaaaa, 32'h55555555, 1'b0);
    add_op(mqfm_pkg::ACT_ENQ, 2'd1, 32'h00000001, 32'hfffffffe, 1'b0);
    add_op(mqfm_pkg::ACT_DEQ, 2'd2, 32'h0, 32'h0, 1'b0);
    add_op(mqfm_pkg::ACT_DEQ, 2'd1, 32'h0, 32'h0, 1'b0);
    add_op(mqfm_pkg::ACT_DEQ, 2'd2, 32'h0, 32'h0, 1'b0);

    // random: segments that lean toward filling or draining the pool
    total = 0;
    seg   = 0;
    while (total < RANDOM_OPS) begin
      if (seg == 0) begin
        enq_pct = 90;  // reach the full pool early
        seg_len = 120;
      end else begin
        case ($urandom_range(0, 2))
          0: enq_pct = 85;
          1: enq_pct = 50;
          default: enq_pct = 15;
        endcase
        seg_len = $urandom_range(40, 120);
      end
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 10;
      endcase
      for (int unsigned k = 0; k < seg_len; k++) begin
        act = ($urandom_range(0, 99) < enq_pct) ? mqfm_pkg::ACT_ENQ : mqfm_pkg::ACT_DEQ;
        sel = ($urandom_range(0, 99) < 4) ? BAD_SEL : 2'($urandom_range(0, NUM_Q - 1));
        add_op(act, sel, $urandom, $urandom,
               (k == 0) && (seg == 2 || $urandom_range(0, 3) == 0));
      end
      total += seg_len;
      seg++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything sent and every reply back
    while (ops_to_send.size() != 0 || cur_loaded || replies_due.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/mqfm_pkg.sv
sv/mqfm_if.sv
sv/mqfm_ram.sv
sv/mqfm_ctrl.sv
sv/multi_queue_fifo_manager.sv
test/testbench.sv
